// File: rtl/core/quad_rect_overlap_test_macros.svh
// assertion helpers, clocked on clk, held off while rst_n is low
`ifndef QUAD_RECT_OVERLAP_TEST_MACROS_SVH
`define QUAD_RECT_OVERLAP_TEST_MACROS_SVH

`define QRO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define QRO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/qro_pkg.sv
`default_nettype none
package qro_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int SIZE_BITS      = 15;
  localparam int NUM_CORNERS    = 4;
  localparam int CFG_ADDR_BITS  = 5;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [2:0] REG_A_X = 3'd0;
  localparam logic [2:0] REG_A_Y = 3'd1;
  localparam logic [2:0] REG_B_X = 3'd2;
  localparam logic [2:0] REG_B_Y = 3'd3;
  localparam logic [2:0] REG_C_X = 3'd4;
  localparam logic [2:0] REG_C_Y = 3'd5;
  localparam logic [2:0] REG_D_X = 3'd6;
  localparam logic [2:0] REG_D_Y = 3'd7;
endpackage
`default_nettype wire

// File: rtl/core/qro_if.sv
`default_nettype none
interface qro_box_if #(parameter int COORD_BITS = qro_pkg::COORD_BITS_DEF) ();
  import qro_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic [SIZE_BITS-1:0]         box_width;
  logic [SIZE_BITS-1:0]         box_height;
  modport source (output valid, box_x, box_y, box_width, box_height, input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, output ready);
endinterface

interface qro_hit_if ();
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

// File: rtl/core/qro_core.sv
`default_nettype none
`include "quad_rect_overlap_test_macros.svh"
module qro_core #(
  parameter int COORD_BITS = qro_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic signed [COORD_BITS-1:0] quad_x [qro_pkg::NUM_CORNERS],
  input  wire logic signed [COORD_BITS-1:0] quad_y [qro_pkg::NUM_CORNERS],
  qro_box_if.sink                           in_beat,
  qro_hit_if.source                         out_beat
);
  import qro_pkg::*;

  localparam int XW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
  localparam int DW = XW + 1;
  localparam int QW = COORD_BITS + 1;
  localparam int PW = DW + QW;
  localparam int SW = PW + 1;

  // zone edges AB, AC, BD, CD
  localparam int EP [4] = '{0, 0, 1, 2};
  localparam int EQ [4] = '{1, 2, 3, 3};
  // box corners: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
  // box edges: left, right, top, bottom
  localparam int BK0 [4] = '{0, 1, 0, 2};
  localparam int BK1 [4] = '{2, 3, 1, 3};

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic hit5_r;

  // stage 1
  logic signed [XW-1:0] bx_e, by_e, bw_e, bh_e;
  logic signed [XW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic                 wne_r, hne_r;

  // stage 2
  logic signed [XW-1:0] zx_e [4];
  logic signed [XW-1:0] zy_e [4];
  logic signed [XW-1:0] kx [4];
  logic signed [XW-1:0] ky [4];
  logic signed [DW-1:0] rx2_r [4][4];
  logic signed [DW-1:0] ry2_r [4][4];
  logic signed [QW-1:0] dx2_r [4];
  logic signed [QW-1:0] dy2_r [4];
  logic [3:0]           in2_r;
  logic [3:0]           xp2_r [4];
  logic [3:0]           in_nxt;
  logic [3:0]           xp_nxt [4];

  // stage 3, 4
  logic signed [PW-1:0] ma3_r [4][4];
  logic signed [PW-1:0] mb3_r [4][4];
  logic [3:0]           in3_r, in4_r;
  logic [3:0]           xp3_r [4];
  logic [3:0]           xp4_r [4];
  logic [3:0]           pos4_r [4];
  logic [3:0]           neg4_r [4];
  logic signed [SW-1:0] cr [4][4];

  logic hit_nxt;

  assign adv           = !v5_r || out_beat.ready;
  assign in_beat.ready = adv;
  assign out_beat.valid = v5_r;
  assign out_beat.hit   = hit5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_beat.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    bx_e = XW'(in_beat.box_x);
    by_e = XW'(in_beat.box_y);
    bw_e = XW'(in_beat.box_width);
    bh_e = XW'(in_beat.box_height);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r  <= bx_e;
      y0_r  <= by_e;
      x1_r  <= bx_e + bw_e - XW'(1);
      y1_r  <= by_e + bh_e - XW'(1);
      wne_r <= in_beat.box_width != SIZE_BITS'(1);
      hne_r <= in_beat.box_height != SIZE_BITS'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      zx_e[c]   = XW'(quad_x[c]);
      zy_e[c]   = XW'(quad_y[c]);
      in_nxt[c] = (zx_e[c] >= x0_r) && (zx_e[c] <= x1_r) &&
                  (zy_e[c] >= y0_r) && (zy_e[c] <= y1_r);
    end
    kx[0] = x0_r; ky[0] = y0_r;
    kx[1] = x1_r; ky[1] = y0_r;
    kx[2] = x0_r; ky[2] = y1_r;
    kx[3] = x1_r; ky[3] = y1_r;
    for (int e = 0; e < 4; e++) begin
      xp_nxt[e][0] = hne_r && (((zx_e[EP[e]] < x0_r) && (zx_e[EQ[e]] > x0_r)) ||
                               ((zx_e[EP[e]] > x0_r) && (zx_e[EQ[e]] < x0_r)));
      xp_nxt[e][1] = hne_r && (((zx_e[EP[e]] < x1_r) && (zx_e[EQ[e]] > x1_r)) ||
                               ((zx_e[EP[e]] > x1_r) && (zx_e[EQ[e]] < x1_r)));
      xp_nxt[e][2] = wne_r && (((zy_e[EP[e]] < y0_r) && (zy_e[EQ[e]] > y0_r)) ||
                               ((zy_e[EP[e]] > y0_r) && (zy_e[EQ[e]] < y0_r)));
      xp_nxt[e][3] = wne_r && (((zy_e[EP[e]] < y1_r) && (zy_e[EQ[e]] > y1_r)) ||
                               ((zy_e[EP[e]] > y1_r) && (zy_e[EQ[e]] < y1_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in2_r <= in_nxt;
      for (int e = 0; e < 4; e++) begin
        xp2_r[e] <= xp_nxt[e];
        dx2_r[e] <= QW'(quad_x[EQ[e]]) - QW'(quad_x[EP[e]]);
        dy2_r[e] <= QW'(quad_y[EQ[e]]) - QW'(quad_y[EP[e]]);
        for (int k = 0; k < 4; k++) begin
          rx2_r[e][k] <= DW'(kx[k]) - DW'(zx_e[EP[e]]);
          ry2_r[e][k] <= DW'(ky[k]) - DW'(zy_e[EP[e]]);
        end
      end
    end
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    if (adv) begin
      in3_r <= in2_r;
      for (int e = 0; e < 4; e++) begin
        xp3_r[e] <= xp2_r[e];
        for (int k = 0; k < 4; k++) begin
          ma3_r[e][k] <= PW'(dx2_r[e] * ry2_r[e][k]);
          mb3_r[e][k] <= PW'(dy2_r[e] * rx2_r[e][k]);
        end
      end
    end
  end

  // stage 4: side of each box corner against each zone edge
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      for (int k = 0; k < 4; k++) begin
        cr[e][k] = SW'(ma3_r[e][k]) - SW'(mb3_r[e][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in4_r <= in3_r;
      for (int e = 0; e < 4; e++) begin
        xp4_r[e] <= xp3_r[e];
        for (int k = 0; k < 4; k++) begin
          pos4_r[e][k] <= cr[e][k] > SW'(0);
          neg4_r[e][k] <= cr[e][k] < SW'(0);
        end
      end
    end
  end

  always_comb begin
    hit_nxt = 1'b0;
    for (int e = 0; e < 4; e++) begin
      if (in4_r[EP[e]] && in4_r[EQ[e]]) begin
        hit_nxt = 1'b1;
      end
      for (int b = 0; b < 4; b++) begin
        if (xp4_r[e][b] &&
            ((pos4_r[e][BK0[b]] && neg4_r[e][BK1[b]]) ||
             (neg4_r[e][BK0[b]] && pos4_r[e][BK1[b]]))) begin
          hit_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit5_r <= hit_nxt;
    end
  end

  `QRO_ASSERT_NEXT(a_load, adv, v1_r == $past(in_beat.valid), "stage 1 valid lost")
  `QRO_ASSERT_NEXT(a_hold, !adv, $stable({v1_r, v2_r, v3_r, v4_r, v5_r}), "pipe moved in stall")
  `QRO_ASSERT_NEXT(a_empty, adv && ((x1_r < x0_r) || (y1_r < y0_r)), in2_r == 4'b0000,
                   "corner inside empty box")
endmodule
`default_nettype wire

// File: rtl/core/quad_rect_overlap_test.sv
// Zone/box overlap test. Corners A-D of a four-sided zone are set over the APB
// port (eight signed registers at byte offsets 0x00..0x1C; the user must write
// them only while idle, which the block does not enforce); each box beat on
// in_beat returns one hit beat on out_beat. A box is accepted every cycle unless
// out_beat stalls; the hit is registered through the bounds, subtract, multiply,
// compare and merge stages of the datapath, which holds 32 multipliers (two per
// zone edge and box corner). Back-pressure on out_beat stalls the whole pipe without loss.
`default_nettype none
module quad_rect_overlap_test #(
  parameter int COORD_BITS = qro_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [qro_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [qro_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic      [qro_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                    cfg_pready,
  qro_box_if.sink                                 in_beat,
  qro_hit_if.source                               out_beat
);
  import qro_pkg::*;

  logic signed [COORD_BITS-1:0] quad_x_r [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] quad_y_r [NUM_CORNERS];
  logic [2:0]                   idx;
  logic                         wr;
  logic signed [COORD_BITS-1:0] wval;
  logic signed [COORD_BITS-1:0] rval;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[CFG_ADDR_BITS-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign wval       = cfg_pwdata[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        quad_x_r[c] <= '0;
        quad_y_r[c] <= '0;
      end
    end else if (wr) begin
      case (idx)
        REG_A_X: quad_x_r[0] <= wval;
        REG_A_Y: quad_y_r[0] <= wval;
        REG_B_X: quad_x_r[1] <= wval;
        REG_B_Y: quad_y_r[1] <= wval;
        REG_C_X: quad_x_r[2] <= wval;
        REG_C_Y: quad_y_r[2] <= wval;
        REG_D_X: quad_x_r[3] <= wval;
        REG_D_Y: quad_y_r[3] <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_A_X: rval = quad_x_r[0];
      REG_A_Y: rval = quad_y_r[0];
      REG_B_X: rval = quad_x_r[1];
      REG_B_Y: rval = quad_y_r[1];
      REG_C_X: rval = quad_x_r[2];
      REG_C_Y: rval = quad_y_r[2];
      REG_D_X: rval = quad_x_r[3];
      REG_D_Y: rval = quad_y_r[3];
      default: rval = '0;
    endcase
    cfg_prdata = CFG_DATA_BITS'(rval);
  end

  qro_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .quad_x   (quad_x_r),
    .quad_y   (quad_y_r),
    .in_beat  (in_beat),
    .out_beat (out_beat)
  );
endmodule
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
  import qro_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  qro_box_if #(.COORD_BITS(CB)) box_ch ();
  qro_hit_if hit_ch ();

  quad_rect_overlap_test #(.COORD_BITS(CB)) dut (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .in_beat(box_ch.sink), .out_beat(hit_ch.source)
  );

  longint corner_x [4];
  longint corner_y [4];
  bit hit_expected [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    box_ch.valid = 1'b0;
    box_ch.box_x = '0;
    box_ch.box_y = '0;
    box_ch.box_width = '0;
    box_ch.box_height = '0;
    hit_ch.ready = 1'b0;
  end

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic int turn(longint ox, longint oy, longint qx, longint qy,
                              longint rx, longint ry);
    return sgn((qx - ox) * (ry - oy) - (qy - oy) * (rx - ox));
  endfunction

  function automatic bit crosses(longint p0x, longint p0y, longint p1x, longint p1y,
                                 longint q0x, longint q0y, longint q1x, longint q1y);
    return (turn(p0x, p0y, q0x, q0y, q1x, q1y) * turn(p1x, p1y, q0x, q0y, q1x, q1y) < 0)
        && (turn(q0x, q0y, p0x, p0y, p1x, p1y) * turn(q1x, q1y, p0x, p0y, p1x, p1y) < 0);
  endfunction

  function automatic bit zone_edge_hits(int i, int j, box_t b);
    longint bx, by, bw, bh, x1, y1, ax, ay, cx, cy;
    bit a_in, c_in;
    bx = b.x; by = b.y;
    bw = longint'(b.w); bh = longint'(b.h);
    x1 = bx + bw - 1; y1 = by + bh - 1;
    ax = corner_x[i]; ay = corner_y[i]; cx = corner_x[j]; cy = corner_y[j];
    a_in = ax >= bx && ax < bx + bw && ay >= by && ay < by + bh;
    c_in = cx >= bx && cx < bx + bw && cy >= by && cy < by + bh;
    return (a_in && c_in) || crosses(bx, by, bx, y1, ax, ay, cx, cy)
        || crosses(x1, by, x1, y1, ax, ay, cx, cy)
        || crosses(bx, by, x1, by, ax, ay, cx, cy)
        || crosses(bx, y1, x1, y1, ax, ay, cx, cy);
  endfunction

  // edges AB, AC, BD, CD
  function automatic bit zone_hit(box_t b);
    return zone_edge_hits(0, 1, b) || zone_edge_hits(0, 2, b)
        || zone_edge_hits(1, 3, b) || zone_edge_hits(2, 3, b);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic signed [CB-1:0] v);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = CFG_ADDR_BITS'(idx) << 2;
    cfg_pwdata = CFG_DATA_BITS'(v);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx[0]) corner_y[idx >> 1] = v;
    else corner_x[idx >> 1] = v;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic set_zone(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
    write_reg(REG_A_X, CB'(ax)); write_reg(REG_A_Y, CB'(ay));
    write_reg(REG_B_X, CB'(bx)); write_reg(REG_B_Y, CB'(by));
    write_reg(REG_C_X, CB'(cx)); write_reg(REG_C_Y, CB'(cy));
    write_reg(REG_D_X, CB'(dx)); write_reg(REG_D_Y, CB'(dy));
  endtask

  task automatic drain();
    @(negedge clk);
    box_ch.valid = 1'b0;
    while (hit_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      box_ch.valid = 1'b0;
    end
    @(negedge clk);
    box_ch.valid = 1'b1;
    box_ch.box_x = b.x; box_ch.box_y = b.y;
    box_ch.box_width = b.w; box_ch.box_height = b.h;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    hit_expected = {hit_expected, zone_hit(b)};
  endtask

  function automatic box_t mk(int x, int y, int w, int h);
    box_t b;
    b.x = CB'(x); b.y = CB'(y); b.w = SIZE_BITS'(w); b.h = SIZE_BITS'(h);
    return b;
  endfunction

  function automatic box_t near_box(int span);
    int cx, cy;
    cx = int'(corner_x[$urandom_range(3)]);
    cy = int'(corner_y[$urandom_range(3)]);
    return mk(cx - int'($urandom_range(span)), cy - int'($urandom_range(span)),
              $urandom_range(2 * span), $urandom_range(2 * span));
  endfunction

  function automatic box_t random_box();
    case ($urandom_range(3))
      0: return mk($urandom, $urandom, $urandom, $urandom);
      1: return near_box(4);
      default: return near_box(40);
    endcase
  endfunction

  // receiver
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hit_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && hit_ch.valid && hit_ch.ready) begin
      if (hit_expected.size() == 0) begin
        $display("%0t: unexpected hit beat, actual %b", $realtime, hit_ch.hit);
        errors++;
      end else begin
        if (hit_ch.hit !== hit_expected[0]) begin
          $display("%0t: hit expected %b actual %b", $realtime, hit_expected[0], hit_ch.hit);
          errors++;
        end
        void'(hit_expected.pop_front());
      end
    end
  end

  task automatic test_reset_zone();
    // all corners at origin after reset
    send_box(mk(0, 0, 1, 1));
    send_box(mk(-1, -1, 2, 2));
    send_box(mk(1, 1, 5, 5));
    drain();
  endtask

  task automatic test_directed();
    set_zone(-100, -100, 100, -100, -100, 100, 100, 100);
    send_box(mk(-10, -10, 20, 20));
    send_box(mk(-200, -200, 500, 500));
    send_box(mk(-100, -100, 201, 1));
    send_box(mk(-150, -50, 100, 10));
    send_box(mk(-100, -100, 1, 1));
    send_box(mk(50, 50, 0, 0));
    send_box(mk(-150, 0, 0, 20));
    send_box(mk(100, 100, 0, 0));
    send_box(mk(-32768, -32768, 32767, 32767));
    send_box(mk(32767, 32767, 32767, 32767));
    send_box(mk(-32768, 32767, 0, 32767));
    drain();
    set_zone(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    send_box(mk(0, 0, 10, 10));
    send_box(mk(-32768, -32768, 32767, 32767));
    send_box(mk(32767, 0, 32767, 1));
    send_box(mk(-32768, -32768, 32767, 1));
    drain();
    // degenerate zone: all corners at one point, and a collinear one
    set_zone(5, 5, 5, 5, 5, 5, 5, 5);
    send_box(mk(0, 0, 10, 10));
    send_box(mk(5, 0, 1, 10));
    send_box(mk(6, 0, 5, 10));
    drain();
    set_zone(0, 0, 10, 0, 0, 0, 10, 0);
    send_box(mk(2, 0, 3, 1));
    send_box(mk(2, -2, 3, 5));
    drain();
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_box(random_box());
    drain();
  endtask

  task automatic random_zone();
    if ($urandom_range(3) == 0)
      set_zone($urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    else
      set_zone($signed($urandom_range(200)) - 100, $signed($urandom_range(200)) - 100,
               $signed($urandom_range(200)) - 100, $signed($urandom_range(200)) - 100,
               $signed($urandom_range(200)) - 100, $signed($urandom_range(200)) - 100,
               $signed($urandom_range(200)) - 100, $signed($urandom_range(200)) - 100);
  endtask

  task automatic test_random();
    random_zone(); random_phase(150, 0, 0);
    random_zone(); random_phase(150, 66, 0);
    random_zone(); random_phase(150, 0, 66);
    random_zone(); random_phase(150, 32, 32);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 10;
    @(negedge clk);
    hold_off = 60;
    repeat (40) send_box(random_box());
    drain();
  endtask

  initial begin
    foreach (corner_x[i]) begin
      corner_x[i] = 0;
      corner_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_zone();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0 && hit_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
